>>> design/tsws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_pkg
// Shared types, codes and constants of the TCP send window segmenter.
// ----------------------------------------------------------------------------
package tsws_pkg;

  localparam int SEQ_W    = 32;
  localparam int WIN_W    = 16;
  localparam int CNT_W    = 13;
  localparam int BUF_W    = 12;  // log2 of the outbound buffer length (4096)
  localparam int PEND_W   = 14;
  localparam int STATUS_W = 2;
  localparam int TREQ_W   = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [WIN_W-1:0] MIN_SEGMENT       = 16'd1024;
  localparam logic [WIN_W-1:0] MSS_RESET         = 16'd1460;
  localparam logic [WIN_W-1:0] PERSIST_DLY_RESET = 16'd100;

  // Register indexes on the configuration port.
  localparam logic REG_MSS         = 1'b0;
  localparam logic REG_PERSIST_DLY = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_SENT  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

  // Timer request codes.
  localparam logic [TREQ_W-1:0] TREQ_NONE    = 2'd0;
  localparam logic [TREQ_W-1:0] TREQ_PERSIST = 2'd1;
  localparam logic [TREQ_W-1:0] TREQ_RETX    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_EMIT
  } tsws_state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic decide;
    logic emit;
  } tsws_cmd_t;

  typedef struct packed {
    logic send;  // decision: at least one segment goes out
    logic more;  // remaining data exceeds one full segment
  } tsws_stat_t;

endpackage

>>> design/tsws_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_regs
// APB configuration registers: segment size and persist timer delay.
// ----------------------------------------------------------------------------
module tsws_regs
  import tsws_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [WIN_W-1:0]  max_segment_size,
  output logic [WIN_W-1:0]  persist_initial_delay
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_segment_size      <= MSS_RESET;
      persist_initial_delay <= PERSIST_DLY_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MSS:         max_segment_size      <= pwdata[WIN_W-1:0];
        REG_PERSIST_DLY: persist_initial_delay <= pwdata[WIN_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MSS:         prdata = {{(DATA_W-WIN_W){1'b0}}, max_segment_size};
      REG_PERSIST_DLY: prdata = {{(DATA_W-WIN_W){1'b0}}, persist_initial_delay};
      default:         prdata = '0;
    endcase
  end

endmodule

>>> design/tsws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_ctrl
// Sequencer: capture, evaluate, decide, then step out one segment per cycle.
// ----------------------------------------------------------------------------
module tsws_ctrl
  import tsws_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  tsws_stat_t stat,
  output tsws_cmd_t  cmd,
  output logic       busy
);

  tsws_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_CALC;
      ST_CALC:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = stat.send ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (!stat.more) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CALC:   cmd.calc   = 1'b1;
      ST_DECIDE: cmd.decide = 1'b1;
      ST_EMIT:   cmd.emit   = 1'b1;
      default:   busy       = 1'b1;
    endcase
  end

endmodule

>>> design/tsws_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_dp
// Datapath: request snapshot, window arithmetic, segment stepping, result
// registers.
// ----------------------------------------------------------------------------
module tsws_dp
  import tsws_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  tsws_cmd_t           cmd,
  output tsws_stat_t          stat,
  input  logic [WIN_W-1:0]    mss,
  input  logic [WIN_W-1:0]    persist_dly,
  input  logic [SEQ_W-1:0]    unacked_seq,
  input  logic [SEQ_W-1:0]    next_seq,
  input  logic [WIN_W-1:0]    peer_window,
  input  logic [CNT_W-1:0]    buffered_count,
  input  logic [BUF_W-1:0]    buffer_start,
  input  logic                fin_pending,
  input  logic                persist_active,
  input  logic                retransmitting,
  input  logic [SEQ_W-1:0]    fin_sequence,
  input  logic [SEQ_W-1:0]    receive_next,
  input  logic                retx_timer_running,
  input  logic [WIN_W-1:0]    retx_delay,
  output logic                strobe,
  output logic                segment_valid,
  output logic                segment_fin,
  output logic [SEQ_W-1:0]    segment_seq,
  output logic [SEQ_W-1:0]    segment_ack,
  output logic [BUF_W-1:0]    segment_offset,
  output logic [WIN_W-1:0]    segment_length,
  output logic                last,
  output logic [STATUS_W-1:0] status,
  output logic [WIN_W-1:0]    sent_total,
  output logic [SEQ_W-1:0]    new_next_seq,
  output logic [TREQ_W-1:0]   timer_request,
  output logic [WIN_W-1:0]    timer_delay
);

  // Request snapshot.
  logic [SEQ_W-1:0] una, nxt, finseq, rnxt;
  logic [WIN_W-1:0] wnd, rdel;
  logic [CNT_W-1:0] count;
  logic [BUF_W-1:0] bstart;
  logic             finp, persist, retx, trun;

  // Evaluation results.
  logic [SEQ_W-1:0] inflight;
  logic             fin_bad, una_before;

  // Segment stepping state.
  logic [SEQ_W-1:0] seq;
  logic [BUF_W-1:0] offset;
  logic [WIN_W-1:0] tosend, sent;
  logic             fin_flag;

  // Decision logic.
  logic [SEQ_W-1:0]    win_left, una_diff, fin_diff;
  logic [PEND_W-1:0]   pending;
  logic                err, full, nodata, send;
  logic [STATUS_W-1:0] one_status;
  logic [TREQ_W-1:0]   one_treq;
  logic [WIN_W-1:0]    one_tdel;
  logic [WIN_W-1:0]    first_tosend;

  assign una_diff = una - nxt;
  assign fin_diff = finseq - nxt;

  // una + wnd compared against nxt reduces to wnd - inflight.
  assign win_left = {{(SEQ_W-WIN_W){1'b0}}, wnd} - inflight;
  assign full     = (win_left == '0) | win_left[SEQ_W-1];
  assign pending  = {1'b0, count} + {{(PEND_W-1){1'b0}}, finp};
  assign nodata   = inflight >= {{(SEQ_W-PEND_W){1'b0}}, pending};
  assign err      = (mss < MIN_SEGMENT) | fin_bad;

  always_comb begin
    send       = 1'b0;
    one_status = STATUS_NONE;
    one_treq   = TREQ_NONE;
    one_tdel   = '0;
    if (err) begin
      one_status = STATUS_ERROR;
    end else if (retx || persist) begin
      one_status = STATUS_NONE;
    end else if (wnd == '0) begin
      one_treq = TREQ_PERSIST;
      one_tdel = persist_dly;
    end else if (full) begin
      one_status = STATUS_NONE;
    end else if (nodata) begin
      if (una_before && !trun) begin
        one_treq = TREQ_RETX;
        one_tdel = rdel;
      end
    end else begin
      send = 1'b1;
    end
  end

  // On the send path inflight is below both the window and pending.
  assign first_tosend = ({2'b0, pending} > wnd) ? (wnd - inflight[WIN_W-1:0])
                        : ({2'b0, pending} - inflight[WIN_W-1:0]);

  assign stat.send = send;
  assign stat.more = tosend > mss;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      una     <= unacked_seq;
      nxt     <= next_seq;
      wnd     <= peer_window;
      count   <= buffered_count;
      bstart  <= buffer_start;
      finp    <= fin_pending;
      persist <= persist_active;
      retx    <= retransmitting;
      finseq  <= fin_sequence;
      rnxt    <= receive_next;
      trun    <= retx_timer_running;
      rdel    <= retx_delay;
    end
    if (cmd.calc) begin
      inflight   <= nxt - una;
      fin_bad    <= finp & fin_diff[SEQ_W-1];
      una_before <= una_diff[SEQ_W-1];
    end
    if (cmd.decide) begin
      seq      <= nxt;
      offset   <= bstart + inflight[BUF_W-1:0];
      tosend   <= first_tosend;
      sent     <= '0;
      fin_flag <= ({2'b0, pending} > wnd) ? 1'b0 : finp;
    end else if (cmd.emit) begin
      seq    <= seq + {{(SEQ_W-WIN_W){1'b0}}, mss};
      offset <= offset + mss[BUF_W-1:0];
      tosend <= tosend - mss;
      sent   <= sent + mss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.decide & ~send) | cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && !send) begin
      segment_valid  <= 1'b0;
      segment_fin    <= 1'b0;
      segment_seq    <= '0;
      segment_ack    <= '0;
      segment_offset <= '0;
      segment_length <= '0;
      last           <= 1'b1;
      status         <= one_status;
      sent_total     <= '0;
      new_next_seq   <= nxt;
      timer_request  <= one_treq;
      timer_delay    <= one_tdel;
    end else if (cmd.emit) begin
      segment_valid  <= 1'b1;
      segment_seq    <= seq;
      segment_ack    <= rnxt;
      segment_offset <= offset;
      status         <= STATUS_SENT;
      if (stat.more) begin
        segment_fin    <= 1'b0;
        segment_length <= mss;
        last           <= 1'b0;
        sent_total     <= '0;
        new_next_seq   <= '0;
        timer_request  <= TREQ_NONE;
        timer_delay    <= '0;
      end else begin
        segment_fin    <= fin_flag;
        segment_length <= tosend;
        last           <= 1'b1;
        sent_total     <= sent + tosend;
        new_next_seq   <= seq + {{(SEQ_W-WIN_W){1'b0}}, tosend};
        timer_request  <= trun ? TREQ_NONE : TREQ_RETX;
        timer_delay    <= trun ? '0 : rdel;
      end
    end
  end

endmodule

>>> design/tcp_send_window_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_send_window_segmenter
// Decides what one connection may transmit and lists the segments to send.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Results follow on
// the result ports, one per cycle, each marked by strobe for a single cycle;
// the receiver cannot stall them, so it must take every transaction as it
// comes. A request that sends nothing holds busy through window and sequence
// evaluation and gives one result; a request that sends N segments (N is at
// most 8, since no more than 8192 sequence units go out and the segment size
// must be at least 1024) also holds busy while the segment stepper produces
// one segment per cycle. The last result carries last.
// ----------------------------------------------------------------------------
module tcp_send_window_segmenter
  import tsws_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [SEQ_W-1:0]    unacked_seq,
  input  logic [SEQ_W-1:0]    next_seq,
  input  logic [WIN_W-1:0]    peer_window,
  input  logic [CNT_W-1:0]    buffered_count,
  input  logic [BUF_W-1:0]    buffer_start,
  input  logic                fin_pending,
  input  logic                persist_active,
  input  logic                retransmitting,
  input  logic [SEQ_W-1:0]    fin_sequence,
  input  logic [SEQ_W-1:0]    receive_next,
  input  logic                retx_timer_running,
  input  logic [WIN_W-1:0]    retx_delay,
  output logic                strobe,
  output logic                segment_valid,
  output logic                segment_fin,
  output logic [SEQ_W-1:0]    segment_seq,
  output logic [SEQ_W-1:0]    segment_ack,
  output logic [BUF_W-1:0]    segment_offset,
  output logic [WIN_W-1:0]    segment_length,
  output logic                last,
  output logic [STATUS_W-1:0] status,
  output logic [WIN_W-1:0]    sent_total,
  output logic [SEQ_W-1:0]    new_next_seq,
  output logic [TREQ_W-1:0]   timer_request,
  output logic [WIN_W-1:0]    timer_delay,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [WIN_W-1:0] max_segment_size;
  logic [WIN_W-1:0] persist_initial_delay;
  tsws_cmd_t        cmd;
  tsws_stat_t       stat;

  tsws_regs u_regs (
    .clk                   (clk),
    .rst                   (rst),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .max_segment_size      (max_segment_size),
    .persist_initial_delay (persist_initial_delay)
  );

  tsws_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tsws_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .mss                (max_segment_size),
    .persist_dly        (persist_initial_delay),
    .unacked_seq        (unacked_seq),
    .next_seq           (next_seq),
    .peer_window        (peer_window),
    .buffered_count     (buffered_count),
    .buffer_start       (buffer_start),
    .fin_pending        (fin_pending),
    .persist_active     (persist_active),
    .retransmitting     (retransmitting),
    .fin_sequence       (fin_sequence),
    .receive_next       (receive_next),
    .retx_timer_running (retx_timer_running),
    .retx_delay         (retx_delay),
    .strobe             (strobe),
    .segment_valid      (segment_valid),
    .segment_fin        (segment_fin),
    .segment_seq        (segment_seq),
    .segment_ack        (segment_ack),
    .segment_offset     (segment_offset),
    .segment_length     (segment_length),
    .last               (last),
    .status             (status),
    .sent_total         (sent_total),
    .new_next_seq       (new_next_seq),
    .timer_request      (timer_request),
    .timer_delay        (timer_delay)
  );

`ifndef SYNTHESIS
  // An accepted request always occupies the block for the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted request");

  // Segments of one request come out in consecutive cycles.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside a segment burst");

  // Every segment before the last one is a full-size segment.
  a_full_seg: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> (segment_valid && segment_length == max_segment_size))
    else $error("non-final segment is not full size");

  // A result without a segment is always the only result of its request.
  a_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && !segment_valid) |-> (last && sent_total == '0))
    else $error("empty result is not final");
`endif

endmodule
